### sv/sfir9_pkg.sv
// shared types and constants for the symmetric 9-tap saturating fir filter
package sfir9_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_COUNT = 5;
    localparam int FRAC_BITS  = 15;
    // pre-added pair (17 bits) times coefficient (16 bits)
    localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
    // nine full-scale products stay below 2^34 in magnitude
    localparam int ACC_W      = 36;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [COEF_COUNT-1:0][COEF_W-1:0] coef_set_t;

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_COEF_OUTER  = 3'd0,
        REG_COEF_SECOND = 3'd1,
        REG_COEF_THIRD  = 3'd2,
        REG_COEF_FOURTH = 3'd3,
        REG_COEF_CENTRE = 3'd4
    } reg_idx_t;

    localparam coef_set_t COEF_RESET = {16'sd10534, 16'sd8344, 16'sd3907, 16'sd860, 16'sd68};

    localparam logic signed [ACC_W-1:0] ACC_SAT_MAX = 36'sd32767;
    localparam logic signed [ACC_W-1:0] ACC_SAT_MIN = -36'sd32768;
    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // handshake control from the top level into the sample window
    typedef struct packed {
        logic load;   // input transfer this cycle
        logic drain;  // window item moves to the output register
    } stage_ctl_t;

endpackage

### sv/sfir9_regs.sv
// apb coefficient register file
module sfir9_regs
    import sfir9_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output coef_set_t            coefs
);

    coef_set_t coef_reg;
    coef_set_t coef_next;
    reg_idx_t  idx;
    logic      wr_en;

    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            case (idx)
                REG_COEF_OUTER:  coef_next[0] = pwdata[COEF_W-1:0];
                REG_COEF_SECOND: coef_next[1] = pwdata[COEF_W-1:0];
                REG_COEF_THIRD:  coef_next[2] = pwdata[COEF_W-1:0];
                REG_COEF_FOURTH: coef_next[3] = pwdata[COEF_W-1:0];
                REG_COEF_CENTRE: coef_next[4] = pwdata[COEF_W-1:0];
                default:         coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // reads return the coefficient sign-extended
    always_comb
    begin
        case (idx)
            REG_COEF_OUTER:  prdata = PDATA_W'($signed(coef_reg[0]));
            REG_COEF_SECOND: prdata = PDATA_W'($signed(coef_reg[1]));
            REG_COEF_THIRD:  prdata = PDATA_W'($signed(coef_reg[2]));
            REG_COEF_FOURTH: prdata = PDATA_W'($signed(coef_reg[3]));
            REG_COEF_CENTRE: prdata = PDATA_W'($signed(coef_reg[4]));
            default:         prdata = '0;
        endcase
    end

    assign coefs = coef_reg;

endmodule

### sv/sfir9_window.sv
// sample window register, newest sample in slot 0, plus its valid flag
module sfir9_window
    import sfir9_pkg::*;
#(
    parameter int TAP_COUNT = 9
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  stage_ctl_t                         ctl,
    input  sample_t                            sample_in,
    output logic [TAP_COUNT-1:0][SAMPLE_W-1:0] window,
    output logic                               win_valid
);

    logic [TAP_COUNT-1:0][SAMPLE_W-1:0] window_reg;
    logic [TAP_COUNT-1:0][SAMPLE_W-1:0] window_next;
    logic                               valid_reg;
    logic                               valid_next;

    always_comb
    begin
        window_next = window_reg;
        valid_next  = valid_reg;
        if (ctl.load)
        begin
            window_next = {window_reg[TAP_COUNT-2:0], sample_in};
            valid_next  = 1'b1;
        end
        else if (ctl.drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            valid_reg  <= valid_next;
        end
    end

    assign window    = window_reg;
    assign win_valid = valid_reg;

endmodule

### sv/sfir9_mac.sv
// symmetric pre-add, parallel multiply, sum, floor shift and saturation
module sfir9_mac
    import sfir9_pkg::*;
#(
    parameter int TAP_COUNT = 9
)
(
    input  logic [TAP_COUNT-1:0][SAMPLE_W-1:0] window,
    input  coef_set_t                          coefs,
    output sample_t                            result
);

    localparam int PAIR_COUNT = TAP_COUNT / 2;
    localparam int CENTRE     = TAP_COUNT / 2;
    localparam int TERM_COUNT = PAIR_COUNT + 1;

    logic signed [ACC_W-1:0] term [TERM_COUNT];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;

    genvar gi;
    generate
        for (gi = 0; gi < PAIR_COUNT; gi++)
        begin : g_pair
            logic signed [SAMPLE_W:0] pre;
            logic signed [PROD_W-1:0] prod;

            // taps gi and TAP_COUNT-1-gi share one coefficient
            assign pre  = {window[gi][SAMPLE_W-1], window[gi]}
                        + {window[TAP_COUNT-1-gi][SAMPLE_W-1], window[TAP_COUNT-1-gi]};
            assign prod = pre * $signed(coefs[gi]);
            assign term[gi] = ACC_W'(prod);
        end

        if (TAP_COUNT % 2 == 1)
        begin : g_centre
            logic signed [SAMPLE_W+COEF_W-1:0] prod_c;

            assign prod_c = $signed(window[CENTRE]) * $signed(coefs[CENTRE]);
            assign term[PAIR_COUNT] = ACC_W'(prod_c);
        end
        else
        begin : g_no_centre
            assign term[PAIR_COUNT] = '0;
        end
    endgenerate

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < TERM_COUNT; i++)
        begin
            acc = acc + term[i];
        end
    end

    // arithmetic shift gives the floor
    assign scaled = acc >>> FRAC_BITS;

    always_comb
    begin
        if (scaled > ACC_SAT_MAX)
        begin
            result = SAMPLE_MAX;
        end
        else if (scaled < ACC_SAT_MIN)
        begin
            result = SAMPLE_MIN;
        end
        else
        begin
            result = scaled[SAMPLE_W-1:0];
        end
    end

endmodule

### sv/symmetric_fir_9_tap_saturating.sv
// top level of the symmetric saturating fir filter with apb coefficient port
//
//   channel   direction  handshake                      payload
//   input     in         in_valid / in_stall            sample_in   (s16)
//   output    out        out_valid / out_stall          sample_out  (s16)
//   config    in/out     psel penable pwrite pready     paddr pwdata prdata
//
// one transfer in per cycle while in_stall is low, one result per input:
// the input transfer lands in the sample window register, and the filtered
// value is loaded into the output register once that register is free.
// reset clears the window (all eight past samples read as zero), both valid
// flags, and loads the default coefficients.
// a stalled output holds its result; the window still takes one more sample,
// and in_stall rises only when both the window and the output are full.
module symmetric_fir_9_tap_saturating
    import sfir9_pkg::*;
#(
    parameter int TAP_COUNT = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    // sample input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  sample_t             sample_in,
    // filtered output channel
    output logic                out_valid,
    input  logic                out_stall,
    output sample_t             sample_out,
    // coefficient register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    coef_set_t                          coefs;
    logic [TAP_COUNT-1:0][SAMPLE_W-1:0] window;
    logic                               win_valid;
    sample_t                            mac_result;
    stage_ctl_t                         ctl;

    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t sample_out_reg;
    logic    out_free;

    assign pready = 1'b1;

    sfir9_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .coefs   (coefs)
    );

    // output register can take a new value when empty or being read
    assign out_free = !out_valid_reg || !out_stall;
    // window stalls only if it holds an item that cannot move on
    assign in_stall  = win_valid && !out_free;
    assign ctl.load  = in_valid && !in_stall;
    assign ctl.drain = win_valid && out_free;

    sfir9_window #(
        .TAP_COUNT (TAP_COUNT)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sample_in (sample_in),
        .window    (window),
        .win_valid (win_valid)
    );

    sfir9_mac #(
        .TAP_COUNT (TAP_COUNT)
    ) u_mac (
        .window (window),
        .coefs  (coefs),
        .result (mac_result)
    );

    // output register
    assign out_valid_next = out_free ? win_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload captured only when a window item moves over
    always_ff @(posedge clk)
    begin
        if (ctl.drain)
        begin
            sample_out_reg <= mac_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // input is held back only when both stages are occupied and blocked
    a_stall_only_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (win_valid && out_valid_reg && out_stall)
    ) else $error("input stalled while a stage was free");

    // an input transfer always leaves a valid item in the window
    a_load_sets_window : assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.load |=> win_valid
    ) else $error("input transfer lost in window");

    // the newest window slot holds the sample just transferred
    a_window_newest : assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.load |=> (window[0] == $past(sample_in))
    ) else $error("window did not shift in the new sample");

    // a window item moving on produces a valid output next cycle
    a_drain_to_output : assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.drain |=> out_valid_reg
    ) else $error("window item did not reach the output register");

endmodule
